[rtl/pdc_pkg.sv]
package pdc_pkg;

   localparam int PAGES    = 256;
   localparam int CLIENTS  = 16;
   localparam int PAGE_W   = 8;
   localparam int CLIENT_W = 5;
   localparam int KIND_W   = 3;
   localparam int MODE_W   = 2;
   localparam int ADDR_W   = $clog2(PAGES);

   // message kinds
   localparam logic [KIND_W-1:0] K_READ_DATA   = 3'd0;
   localparam logic [KIND_W-1:0] K_FETCH_READ  = 3'd1;
   localparam logic [KIND_W-1:0] K_FETCH_WRITE = 3'd2;
   localparam logic [KIND_W-1:0] K_INVALIDATE  = 3'd3;
   localparam logic [KIND_W-1:0] K_WRITE_GRANT = 3'd4;
   localparam logic [KIND_W-1:0] K_WRITE_DATA  = 3'd5;
   localparam logic [KIND_W-1:0] K_ERROR       = 3'd6;

   // page modes
   localparam logic [MODE_W-1:0] M_UNTOUCHED = 2'd0;
   localparam logic [MODE_W-1:0] M_SHARED    = 2'd1;
   localparam logic [MODE_W-1:0] M_EXCLUSIVE = 2'd2;

   // fault kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [CLIENT_W-1:0] owner;
      logic [CLIENTS-1:0]  sharers;
   } pdc_entry_type;

   localparam int ENTRY_W = $bits(pdc_entry_type);

endpackage

[rtl/pdc_if.sv]
interface pdc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [pdc_pkg::PAGE_W-1:0]   page;
   logic [pdc_pkg::CLIENT_W-1:0] client;

   modport source (output valid, output op, output page, output client, input ready);
   modport sink (input valid, input op, input page, input client, output ready);
endinterface

interface pdc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pdc_pkg::KIND_W-1:0]   kind;
   logic [pdc_pkg::CLIENT_W-1:0] target;
   logic [pdc_pkg::PAGE_W-1:0]   page_out;
   logic                         last;

   modport source (output valid, output kind, output target, output page_out, output last,
                   input ready);
   modport sink (input valid, input kind, input target, input page_out, input last,
                 output ready);
endinterface

[rtl/pdc_ram.sv]
module pdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/page_directory_coherence_unit.sv]
// path: a good fault goes through accept, the lookup state (directory read) and send, which
// loads the output register; a bad fault skips the lookup. throughput: one message per cycle
// while the output is free; the input is held through accept, directory read and each send
// reset: a sweep writes every directory entry back to untouched; no item is
// accepted until it completes
module page_directory_coherence_unit (
   input logic      clock,
   input logic      reset,
   pdc_req_if.sink  req_chan,
   pdc_rsp_if.source rsp_chan
);
   import pdc_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;
   localparam logic [1:0] ST_SEND   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                op_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic [CLIENT_W-1:0] client_ff;
   logic                fetch_ff, fetch_in;
   logic [KIND_W-1:0]   fetch_kind_ff, fetch_kind_in;
   logic [CLIENT_W-1:0] owner_ff, owner_in;
   logic [CLIENTS-1:0]  mask_ff, mask_in;
   logic [KIND_W-1:0]   fin_kind_ff, fin_kind_in;

   logic                out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]   out_kind_ff, out_kind_in;
   logic [CLIENT_W-1:0] out_target_ff, out_target_in;
   logic [PAGE_W-1:0]   out_page_ff;
   logic                out_last_ff, out_last_in;
   logic                out_load;

   logic                accept, bad_req, out_free;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   pdc_entry_type       ram_wdata, entry, entry_new;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic [CLIENTS-1:0]  cbit, obit;
   logic                owner_ok;
   logic [CLIENT_W-1:0] low_idx;

   pdc_ram #(.WIDTH(ENTRY_W), .DEPTH(PAGES)) u_dir (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (req_chan.page[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign entry    = pdc_entry_type'(ram_rdata);
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign bad_req  = (req_chan.client == '0) || (7'(req_chan.client) > 7'(CLIENTS))
                     || (17'(req_chan.page) >= 17'(PAGES));

   assign cbit     = CLIENTS'(1) << (client_ff - CLIENT_W'(1));
   assign owner_ok = (entry.owner != '0) && (7'(entry.owner) <= 7'(CLIENTS));
   assign obit     = owner_ok ? (CLIENTS'(1) << (entry.owner - CLIENT_W'(1))) : '0;

   // new directory entry and message plan from the entry just read
   always_comb begin
      entry_new     = entry;
      fetch_in      = 1'b0;
      fetch_kind_in = K_FETCH_READ;
      owner_in      = entry.owner;
      mask_in       = '0;
      fin_kind_in   = K_WRITE_DATA;
      if (op_ff == OP_READ) begin
         entry_new.mode    = M_SHARED;
         entry_new.sharers = entry.sharers | cbit;
         fin_kind_in       = K_READ_DATA;
         if (entry.mode == M_EXCLUSIVE) begin
            fetch_in          = 1'b1;
            entry_new.sharers = entry.sharers | cbit | obit;
         end
      end else begin
         entry_new.mode  = M_EXCLUSIVE;
         entry_new.owner = client_ff;
         if (entry.mode == M_EXCLUSIVE) begin
            fetch_in      = 1'b1;
            fetch_kind_in = K_FETCH_WRITE;
         end else if (entry.mode == M_SHARED) begin
            mask_in           = entry.sharers & ~cbit;
            entry_new.sharers = '0;
            fin_kind_in       = ((entry.sharers & cbit) != '0) ? K_WRITE_GRANT : K_WRITE_DATA;
         end
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = page_ff[ADDR_W-1:0];
      ram_wdata = entry_new;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_LOOKUP) begin
         ram_we = 1'b1;
      end
   end

   // lowest pending sharer
   always_comb begin
      low_idx = '0;
      for (int i = CLIENTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = CLIENT_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      out_load      = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_kind_in   = fin_kind_ff;
      out_target_in = client_ff;
      out_last_in   = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(PAGES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = bad_req ? ST_SEND : ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               if (fetch_ff) begin
                  out_kind_in   = fetch_kind_ff;
                  out_target_in = owner_ff;
                  out_last_in   = 1'b0;
               end else if (mask_ff != '0) begin
                  out_kind_in   = K_INVALIDATE;
                  out_target_in = low_idx + CLIENT_W'(1);
                  out_last_in   = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_chan.op;
         page_ff     <= req_chan.page;
         client_ff   <= req_chan.client;
         fetch_ff    <= 1'b0;
         mask_ff     <= '0;
         fin_kind_ff <= K_ERROR;
      end else if (state_ff == ST_LOOKUP) begin
         fetch_ff      <= fetch_in;
         fetch_kind_ff <= fetch_kind_in;
         owner_ff      <= owner_in;
         mask_ff       <= mask_in;
         fin_kind_ff   <= fin_kind_in;
      end else if (out_load) begin
         if (fetch_ff) begin
            fetch_ff <= 1'b0;
         end else begin
            mask_ff <= mask_ff & (mask_ff - CLIENTS'(1));
         end
      end
      if (out_load) begin
         out_kind_ff   <= out_kind_in;
         out_target_ff <= out_target_in;
         out_page_ff   <= page_ff;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.kind     = out_kind_ff;
   assign rsp_chan.target   = out_target_ff;
   assign rsp_chan.page_out = out_page_ff;
   assign rsp_chan.last     = out_last_ff;

endmodule

[test/page_directory_coherence_unit_tb.sv]
`timescale 1ns / 100ps

module page_directory_coherence_unit_tb;
   import pdc_pkg::*;

   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic                op;
      logic [PAGE_W-1:0]   page;
      logic [CLIENT_W-1:0] client;
   } fault_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CLIENT_W-1:0] target;
      logic [PAGE_W-1:0]   page_out;
      logic                last;
   } msg_type;

   // rows with typed set carry a single expected message; the rest go to the predictor
   typedef struct {
      logic                op;
      logic [PAGE_W-1:0]   page;
      logic [CLIENT_W-1:0] client;
      bit                  typed;
      logic [KIND_W-1:0]   kind;
      logic [CLIENT_W-1:0] target;
   } fault_row_type;

   logic clock = 1'b0;
   logic reset;

   pdc_req_if req_chan ();
   pdc_rsp_if rsp_chan ();

   page_directory_coherence_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #200000;
      $display("TB_ERROR");
      $finish;
   end

   fault_row_type fault_script [18] = '{
      '{OP_READ,  8'd0,   5'd1,  1'b1, K_READ_DATA,  5'd1},
      '{OP_WRITE, 8'd255, 5'd16, 1'b1, K_WRITE_DATA, 5'd16},
      '{OP_READ,  8'd0,   5'd0,  1'b1, K_ERROR,      5'd0},
      '{OP_WRITE, 8'd255, 5'd31, 1'b1, K_ERROR,      5'd31},
      '{OP_READ,  8'd128, 5'd17, 1'b1, K_ERROR,      5'd17},
      '{OP_READ,  8'd255, 5'd1,  1'b0, 'x,           'x},
      '{OP_WRITE, 8'd255, 5'd16, 1'b0, 'x,           'x},
      '{OP_WRITE, 8'd255, 5'd16, 1'b0, 'x,           'x},
      '{OP_WRITE, 8'd255, 5'd5,  1'b0, 'x,           'x},
      '{OP_READ,  8'd7,   5'd9,  1'b0, 'x,           'x},
      '{OP_READ,  8'd7,   5'd2,  1'b0, 'x,           'x},
      '{OP_READ,  8'd7,   5'd16, 1'b0, 'x,           'x},
      '{OP_WRITE, 8'd7,   5'd4,  1'b0, 'x,           'x},
      '{OP_READ,  8'd7,   5'd4,  1'b0, 'x,           'x},
      '{OP_WRITE, 8'd0,   5'd1,  1'b0, 'x,           'x},
      '{OP_READ,  8'd128, 5'd15, 1'b1, K_READ_DATA,  5'd15},
      '{OP_WRITE, 8'd128, 5'd15, 1'b0, 'x,           'x},
      '{OP_WRITE, 8'd64,  5'd0,  1'b1, K_ERROR,      5'd0}
   };

   logic [MODE_W-1:0]   dir_mode    [PAGES];
   logic [CLIENT_W-1:0] dir_owner   [PAGES];
   logic [CLIENTS-1:0]  dir_sharers [PAGES];

   msg_type owed_msgs [$];

   int mismatches = 0;
   int faults_done = 0;
   int msgs_checked = 0;
   int longest_run = 0;
   int invalidates = 0;
   int rejects = 0;
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_off_req = 0;

   // directory update for one fault, producing its message run in order
   task automatic resolve_fault(input fault_type f, ref msg_type msgs[$]);
      logic [CLIENTS-1:0] held;
      logic [CLIENT_W-1:0] owner;
      bit was_sharer;
      msgs.delete();
      if (f.client == 0 || f.client > CLIENTS) begin
         msgs.push_back('{K_ERROR, f.client, f.page, 1'b1});
         return;
      end
      owner = dir_owner[f.page];
      if (f.op == OP_READ) begin
         dir_sharers[f.page][f.client - 1] = 1'b1;
         if (dir_mode[f.page] == M_EXCLUSIVE) begin
            msgs.push_back('{K_FETCH_READ, owner, f.page, 1'b0});
            if (owner != 0 && owner <= CLIENTS)
               dir_sharers[f.page][owner - 1] = 1'b1;
         end
         dir_mode[f.page] = M_SHARED;
         msgs.push_back('{K_READ_DATA, f.client, f.page, 1'b1});
      end else if (dir_mode[f.page] == M_EXCLUSIVE) begin
         msgs.push_back('{K_FETCH_WRITE, owner, f.page, 1'b0});
         dir_owner[f.page] = f.client;
         msgs.push_back('{K_WRITE_DATA, f.client, f.page, 1'b1});
      end else if (dir_mode[f.page] == M_SHARED) begin
         held = dir_sharers[f.page];
         was_sharer = held[f.client - 1];
         for (int c = 1; c <= CLIENTS; c++) begin
            if (c != f.client && held[c - 1])
               msgs.push_back('{K_INVALIDATE, CLIENT_W'(c), f.page, 1'b0});
         end
         dir_sharers[f.page] = '0;
         dir_mode[f.page] = M_EXCLUSIVE;
         dir_owner[f.page] = f.client;
         msgs.push_back('{was_sharer ? K_WRITE_GRANT : K_WRITE_DATA, f.client, f.page, 1'b1});
      end else begin
         dir_mode[f.page] = M_EXCLUSIVE;
         dir_owner[f.page] = f.client;
         msgs.push_back('{K_WRITE_DATA, f.client, f.page, 1'b1});
      end
   endtask

   // called just after a rising edge; returns at the edge that takes the item
   task automatic offer_fault(input fault_type f);
      int gap;
      if ($urandom_range(99) < req_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.op     <= f.op;
      req_chan.page   <= f.page;
      req_chan.client <= f.client;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic issue_fault(input fault_type f, input bit typed, input msg_type fixed);
      msg_type msgs [$];
      offer_fault(f);
      resolve_fault(f, msgs);
      if (typed) begin
         owed_msgs.push_back(fixed);
      end else begin
         foreach (msgs[i]) owed_msgs.push_back(msgs[i]);
      end
      foreach (msgs[i]) begin
         if (msgs[i].kind == K_INVALIDATE) invalidates++;
         if (msgs[i].kind == K_ERROR) rejects++;
      end
      if (msgs.size() > longest_run) longest_run = msgs.size();
      faults_done++;
   endtask

   function automatic fault_type random_fault();
      logic [PAGE_W-1:0] hot_pages [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};
      fault_type f;
      f.op = 1'($urandom_range(1));
      // most faults land on a few pages so their state keeps moving
      if ($urandom_range(99) < 80) f.page = hot_pages[$urandom_range(3)];
      else f.page = PAGE_W'($urandom_range(PAGES - 1));
      if ($urandom_range(99) < 8) begin
         f.client = $urandom_range(1) ? 5'd0 : CLIENT_W'($urandom_range(31, CLIENTS + 1));
      end else begin
         f.client = CLIENT_W'($urandom_range(CLIENTS, 1));
      end
      return f;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) issue_fault(random_fault(), 1'b0, '0);
   endtask

   // every client reads one page, then one of them writes it: the longest run
   task automatic sharing_burst();
      int order [CLIENTS];
      int j;
      int tmp;
      fault_type f;
      for (int i = 0; i < CLIENTS; i++) order[i] = i + 1;
      for (int i = CLIENTS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      f.page = PAGE_W'($urandom_range(PAGES - 1));
      f.op = OP_READ;
      for (int i = 0; i < CLIENTS; i++) begin
         f.client = CLIENT_W'(order[i]);
         issue_fault(f, 1'b0, '0);
      end
      f.op = OP_WRITE;
      f.client = CLIENT_W'($urandom_range(CLIENTS, 1));
      issue_fault(f, 1'b0, '0);
   endtask

   task automatic wait_drained();
      while (owed_msgs.size() != 0) @(posedge clock);
   endtask

   task automatic note_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_msg();
      msg_type want;
      if (owed_msgs.size() == 0) begin
         $display("%0t: message with none expected: kind %0d target %0d page %0d last %0d",
                  $time, rsp_chan.kind, rsp_chan.target, rsp_chan.page_out, rsp_chan.last);
         mismatches++;
         return;
      end
      want = owed_msgs.pop_front();
      msgs_checked++;
      note_field("kind", 8'(want.kind), 8'(rsp_chan.kind));
      note_field("target", 8'(want.target), 8'(rsp_chan.target));
      note_field("page", want.page_out, rsp_chan.page_out);
      note_field("last", 8'(want.last), 8'(rsp_chan.last));
   endtask

   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) check_msg();
         if (hold_off_req != hold_seen) begin
            hold_seen = hold_off_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : req_side
      fault_type f;
      msg_type fixed;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.op = OP_READ;
      req_chan.page = '0;
      req_chan.client = '0;
      req_idle_pct = 22;
      rsp_idle_pct = 22;
      for (int p = 0; p < PAGES; p++) begin
         dir_mode[p] = M_UNTOUCHED;
         dir_owner[p] = '0;
         dir_sharers[p] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (fault_script[i]) begin
         f = '{fault_script[i].op, fault_script[i].page, fault_script[i].client};
         fixed = '{fault_script[i].kind, fault_script[i].target, fault_script[i].page, 1'b1};
         issue_fault(f, fault_script[i].typed, fixed);
      end

      run_random(20);

      // let everything drain, then starve the output while faults keep coming
      req_chan.valid <= 1'b0;
      wait_drained();
      hold_off_req <= hold_off_req + 1;
      req_idle_pct = 0;
      run_random(8);

      // no idling on either side for a while
      rsp_idle_pct = 0;
      sharing_burst();
      run_random(10);

      req_idle_pct = 22;
      rsp_idle_pct = 22;
      sharing_burst();
      run_random(10);

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("%0d faults sent, %0d messages checked, longest run %0d messages",
               faults_done, msgs_checked, longest_run);
      $display("%0d invalidates and %0d rejected clients seen, with stalls on both sides",
               invalidates, rejects);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
